@@ src/rlpe_pkg.sv @@
// Shared types, constants and register codes for the RGB LED pulse encoder.
`timescale 1ns / 1ps

package rlpe_pkg;

  // Field widths
  localparam int CHAN_W       = 8;
  localparam int TIME_W       = 10;
  localparam int LEN_W        = 11;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int PIX_BITS     = 3 * CHAN_W;
  localparam int BIT_CNT_W    = $clog2(PIX_BITS);
  localparam int PROD_W       = 2 * CHAN_W;

  // Port packing
  localparam int S_TDATA_W    = 4 * CHAN_W;
  localparam int M_TDATA_W    = 24;
  localparam int M_TUSER_W    = 2;

  // Defaults
  localparam int MAX_PIXELS_DEF = 1024;
  localparam int QUEUE_DEPTH    = 2;

  // Reset values of the timing and frame registers
  localparam logic [TIME_W-1:0] ONE_HIGH_RST  = TIME_W'(76);
  localparam logic [TIME_W-1:0] ONE_LOW_RST   = TIME_W'(43);
  localparam logic [TIME_W-1:0] ZERO_HIGH_RST = TIME_W'(43);
  localparam logic [TIME_W-1:0] ZERO_LOW_RST  = TIME_W'(96);
  localparam logic [LEN_W-1:0]  SPLIT_RST     = LEN_W'(512);
  localparam logic [LEN_W-1:0]  FRAME_RST     = LEN_W'(1024);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME     = 3'd5;

  // Scaling c*a*4/1275: reciprocal of 1275/4 in 2^-24 units, then one fix-up
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 16;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd4 << RECIP_SHIFT) / 64'd1275);
  localparam int NUM_W       = PROD_W + 2;
  localparam logic [NUM_W-1:0] DIVISOR = NUM_W'(1275);

  typedef struct packed {
    logic [TIME_W-1:0] one_high;
    logic [TIME_W-1:0] one_low;
    logic [TIME_W-1:0] zero_high;
    logic [TIME_W-1:0] zero_low;
  } pulse_timing_t;

  // One scaled pixel waiting to be serialized
  typedef struct packed {
    logic [PIX_BITS-1:0] bits;       // green, red, blue from the top down
    logic                line;
    logic                last_pixel;
  } pix_entry_t;

endpackage

@@ src/rlpe_front.sv @@
// Front end: takes pixels, scales channels, tracks pixel index and line choice.
`timescale 1ns / 1ps

module rlpe_front
  import rlpe_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    alpha,
  input  logic [LEN_W-1:0]     split_count,
  input  logic [LEN_W-1:0]     frame_length,
  output logic                 push,
  output pix_entry_t           push_entry,
  input  logic                 queue_full
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PIXELS);

  logic [IDX_W-1:0]  pixel_index;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  idx_inc;
  logic [CMP_W-1:0]  fl_raw;
  logic [CMP_W-1:0]  fl_eff;
  logic              line_sel;
  logic              last_pixel;
  logic              adv;
  logic              accept;

  // Stage 1: channel products
  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod [3];
  logic              s1_line;
  logic              s1_last;

  // Stage 2: reciprocal estimate
  logic              s2_valid;
  logic [PROD_W-1:0] s2_prod [3];
  logic [CHAN_W-1:0] s2_est  [3];
  logic              s2_line;
  logic              s2_last;

  logic [CHAN_W-1:0] chan_q  [3];

  // Pipeline moves unless its end is blocked by a full queue
  assign adv      = !(s2_valid && queue_full);
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Frame position of the incoming pixel
  always_comb begin
    idx_ext = CMP_W'(pixel_index);
    idx_inc = idx_ext + CMP_W'(1);
    fl_raw  = CMP_W'(frame_length);
    if (fl_raw == '0) begin
      fl_eff = CMP_W'(1);
    end else if (fl_raw > MAX_LEN) begin
      fl_eff = MAX_LEN;
    end else begin
      fl_eff = fl_raw;
    end
    line_sel   = !(idx_ext < CMP_W'(split_count));
    last_pixel = (idx_inc >= fl_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
    end else if (accept) begin
      pixel_index <= last_pixel ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Products in sending order: green, red, blue
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod[0] <= green * alpha;
      s1_prod[1] <= red   * alpha;
      s1_prod[2] <= blue  * alpha;
      s1_line    <= line_sel;
      s1_last    <= last_pixel;
    end
  end

  // Estimate floor(4p/1275) from below, at most one short
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_prod[i] <= s1_prod[i];
        s2_est[i]  <= CHAN_W'((32'(s1_prod[i]) * 32'(RECIP)) >> RECIP_SHIFT);
      end
      s2_line <= s1_line;
      s2_last <= s1_last;
    end
  end

  // Remainder check closes the estimate
  always_comb begin
    logic [NUM_W-1:0] rem;
    for (int i = 0; i < 3; i++) begin
      rem = {s2_prod[i], 2'b00} - NUM_W'(s2_est[i]) * DIVISOR;
      chan_q[i] = (rem >= DIVISOR) ? s2_est[i] + CHAN_W'(1) : s2_est[i];
    end
  end

  assign push                  = s2_valid && !queue_full;
  assign push_entry.bits       = {chan_q[0], chan_q[1], chan_q[2]};
  assign push_entry.line       = s2_line;
  assign push_entry.last_pixel = s2_last;

endmodule

@@ src/rlpe_queue.sv @@
// Short queue of scaled pixels between the front end and the serializer.
`timescale 1ns / 1ps

module rlpe_queue
  import rlpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pix_entry_t push_entry,
  input  logic       pop,
  output pix_entry_t pop_entry,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/rlpe_back.sv @@
// Back end: shifts each pixel out as 24 pulse words through an output register.
`timescale 1ns / 1ps

module rlpe_back
  import rlpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  pix_entry_t           pop_entry,
  output logic                 pop,
  input  pulse_timing_t        timing,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 bit_value,
  output logic [TIME_W-1:0]    high_time,
  output logic [TIME_W-1:0]    low_time,
  output logic                 line_select,
  output logic                 last_of_pixel,
  output logic                 last_in_frame
);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIX_BITS - 1);

  logic                 active;
  logic [PIX_BITS-1:0]  shreg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 cur_line;
  logic                 cur_last;
  logic                 load;
  logic                 emit;
  logic                 done;
  logic                 cur_bit;

  assign load    = !out_valid || out_ready;
  assign emit    = active && load;
  assign done    = emit && (bit_cnt == LAST_BIT);
  assign pop     = !queue_empty && (!active || done);
  assign cur_bit = shreg[PIX_BITS-1];

  // Shifter walks the pixel most significant bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg    <= pop_entry.bits;
      bit_cnt  <= '0;
      cur_line <= pop_entry.line;
      cur_last <= pop_entry.last_pixel;
    end else if (emit) begin
      shreg   <= {shreg[PIX_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bit_value     <= cur_bit;
      high_time     <= cur_bit ? timing.one_high : timing.zero_high;
      low_time      <= cur_bit ? timing.one_low : timing.zero_low;
      line_select   <= cur_line;
      last_of_pixel <= (bit_cnt == LAST_BIT);
      last_in_frame <= (bit_cnt == LAST_BIT) && cur_last;
    end
  end

endmodule

@@ src/rgb_led_pulse_encoder.sv @@
// Top level of the RGB LED pulse encoder: config registers and stream ports.
`timescale 1ns / 1ps

// Each pixel word yields 24 pulse words, one per cycle while the output is not
// stalled; in steady flow the serializer's one-bit-per-cycle shift paces the pixels.
// The first pulse word of a pixel passes through the two scaling stages, the queue,
// the shifter and the output word register on its way to the output.
// Synchronous reset clears the pixel index, queue and handshakes and loads the
// timing and frame registers with their defaults.
module rgb_led_pulse_encoder
  import rlpe_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,    // red, green, blue, alpha
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,    // bit_value, high_time, low_time, zero pad
  output logic                  m_tlast,    // last_of_pixel
  output logic [M_TUSER_W-1:0]  m_tuser,    // line_select, last_in_frame
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  pulse_timing_t       timing;
  logic [LEN_W-1:0]    split_count;
  logic [LEN_W-1:0]    frame_length;
  logic                push;
  pix_entry_t          push_entry;
  logic                pop;
  pix_entry_t          pop_entry;
  logic                queue_full;
  logic                queue_empty;
  logic                bit_value;
  logic [TIME_W-1:0]   high_time;
  logic [TIME_W-1:0]   low_time;
  logic                line_select;
  logic                last_in_frame;

  // Configuration register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.one_high  <= ONE_HIGH_RST;
      timing.one_low   <= ONE_LOW_RST;
      timing.zero_high <= ZERO_HIGH_RST;
      timing.zero_low  <= ZERO_LOW_RST;
      split_count      <= SPLIT_RST;
      frame_length     <= FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  timing.one_high  <= cfg_data[TIME_W-1:0];
        REG_ONE_LOW:   timing.one_low   <= cfg_data[TIME_W-1:0];
        REG_ZERO_HIGH: timing.zero_high <= cfg_data[TIME_W-1:0];
        REG_ZERO_LOW:  timing.zero_low  <= cfg_data[TIME_W-1:0];
        REG_SPLIT:     split_count      <= cfg_data[LEN_W-1:0];
        REG_FRAME:     frame_length     <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  rlpe_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .red          (s_tdata[7:0]),
    .green        (s_tdata[15:8]),
    .blue         (s_tdata[23:16]),
    .alpha        (s_tdata[31:24]),
    .split_count  (split_count),
    .frame_length (frame_length),
    .push         (push),
    .push_entry   (push_entry),
    .queue_full   (queue_full)
  );

  rlpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (queue_full),
    .empty      (queue_empty)
  );

  rlpe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .timing        (timing),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .bit_value     (bit_value),
    .high_time     (high_time),
    .low_time      (low_time),
    .line_select   (line_select),
    .last_of_pixel (m_tlast),
    .last_in_frame (last_in_frame)
  );

  // Output word packing
  assign m_tdata = {3'b000, low_time, high_time, bit_value};
  assign m_tuser = {last_in_frame, line_select};

endmodule

@@ bench/tb_rgb_led_pulse_encoder.sv @@
// Testbench for the RGB LED pulse encoder: directed and random pixels, checked pulse by pulse.
`timescale 1ns / 1ps

module tb_rgb_led_pulse_encoder;
  import rlpe_pkg::*;

  // Indexes with no register behind them; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // One expected pulse word
  typedef struct packed {
    logic              bit_value;
    logic [TIME_W-1:0] high_time;
    logic [TIME_W-1:0] low_time;
    logic              line_select;
    logic              last_of_pixel;
    logic              last_in_frame;
  } pulse_t;

  pulse_t expected_pulses[$];

  // Predictor copy of the registers and pixel index
  logic [TIME_W-1:0] exp_one_high;
  logic [TIME_W-1:0] exp_one_low;
  logic [TIME_W-1:0] exp_zero_high;
  logic [TIME_W-1:0] exp_zero_low;
  logic [LEN_W-1:0]  exp_split;
  logic [LEN_W-1:0]  exp_frame;
  int unsigned       pix_index;

  bit calm = 1'b0;          // no idling on either side while set
  int n_errors = 0;
  int n_pixels = 0;
  int n_pulses = 0;
  int n_writes = 0;

  rgb_led_pulse_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls about a quarter of the time
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 24);
    end
  end

  // c * a * 0.8 / 255 in exact integers
  function automatic int unsigned scaled(input int unsigned c, input int unsigned a);
    return (c * a * 4) / 1275;
  endfunction

  // Work out the 24 pulse words of one pixel and advance the pixel index
  task automatic push_pixel_pulses(input logic [S_TDATA_W-1:0] w);
    int unsigned chan[3];
    int unsigned fl;
    logic        line;
    logic        last_pix;
    pulse_t      p;
    int          k;
    fl = (exp_frame == 0) ? 1 : ((exp_frame > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : exp_frame);
    line = (pix_index < exp_split) ? 1'b0 : 1'b1;
    last_pix = (pix_index + 1 >= fl);
    // green, red, blue on the wire
    chan[0] = scaled(w[15:8], w[31:24]);
    chan[1] = scaled(w[7:0], w[31:24]);
    chan[2] = scaled(w[23:16], w[31:24]);
    k = 0;
    for (int s = 0; s < 3; s++) begin
      for (int b = 7; b >= 0; b--) begin
        p.bit_value     = chan[s][b];
        p.high_time     = p.bit_value ? exp_one_high : exp_zero_high;
        p.low_time      = p.bit_value ? exp_one_low : exp_zero_low;
        p.line_select   = line;
        p.last_of_pixel = (k == 23);
        p.last_in_frame = (k == 23) && last_pix;
        expected_pulses.push_back(p);
        k++;
      end
    end
    pix_index = last_pix ? 0 : pix_index + 1;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // Compare every accepted pulse word with the oldest expectation
  always @(posedge clk) begin
    pulse_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pulses.size() == 0) begin
        $error("pulse word with nothing expected: tdata %h", m_tdata);
        n_errors++;
      end else begin
        e = expected_pulses.pop_front();
        check_field("bit_value", e.bit_value, m_tdata[0]);
        check_field("high_time", e.high_time, m_tdata[10:1]);
        check_field("low_time", e.low_time, m_tdata[20:11]);
        check_field("tdata_pad", 0, m_tdata[23:21]);
        check_field("last_of_pixel", e.last_of_pixel, m_tlast);
        check_field("line_select", e.line_select, m_tuser[0]);
        check_field("last_in_frame", e.last_in_frame, m_tuser[1]);
        n_pulses++;
      end
    end
  end

  // Register write; block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    logic [CFG_W-1:0] d;
    d = val[CFG_W-1:0];
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ONE_HIGH:  exp_one_high  = d[TIME_W-1:0];
      REG_ONE_LOW:   exp_one_low   = d[TIME_W-1:0];
      REG_ZERO_HIGH: exp_zero_high = d[TIME_W-1:0];
      REG_ZERO_LOW:  exp_zero_low  = d[TIME_W-1:0];
      REG_SPLIT:     exp_split     = d[LEN_W-1:0];
      REG_FRAME:     exp_frame     = d[LEN_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic write_timing(input int unsigned oh, input int unsigned ol,
                              input int unsigned zh, input int unsigned zl);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
  endtask

  // Send one pixel word, with a random gap in front unless calm
  task automatic send_pixel(input logic [S_TDATA_W-1:0] w);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 24) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    push_pixel_pulses(w);
    n_pixels++;
  endtask

  // Stop sending and wait for every expected pulse word, then the pipeline latency
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [S_TDATA_W-1:0] pack_pixel(input int r, input int g,
                                                       input int b, input int a);
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  function automatic logic [S_TDATA_W-1:0] rand_pixel();
    logic [S_TDATA_W-1:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: w[31:24] = 8'hff;
      1: w[31:24] = 8'h00;
      2: w[23:0]  = 24'hffffff;
      3: w[23:0]  = 24'h000000;
      default: ;
    endcase
    return w;
  endfunction

  function automatic int unsigned rand_time();
    case ($urandom_range(3))
      0: return 1;
      1: return 1023;
      default: return $urandom_range(1023, 1);
    endcase
  endfunction

  // Channel and alpha extremes at reset timings
  task automatic test_scaling();
    send_pixel(pack_pixel(0, 0, 0, 0));
    send_pixel(pack_pixel(255, 255, 255, 255));
    send_pixel(pack_pixel(255, 0, 0, 255));
    send_pixel(pack_pixel(0, 255, 0, 255));
    send_pixel(pack_pixel(0, 0, 255, 255));
    send_pixel(pack_pixel(255, 255, 255, 0));
    send_pixel(pack_pixel(255, 255, 255, 1));
    send_pixel(pack_pixel(1, 1, 1, 255));
    // 127 and 128 after scaling: every bit flips
    send_pixel(pack_pixel(255, 255, 255, 159));
    send_pixel(pack_pixel(255, 255, 255, 160));
    send_pixel(pack_pixel(170, 85, 204, 200));
    wait_drained();
  endtask

  // Timing extremes, masking, zero pass-through and unused indexes
  task automatic test_timing();
    write_timing(1023, 1, 1, 1023);
    send_pixel(pack_pixel(255, 0, 170, 255));
    send_pixel(pack_pixel(85, 255, 0, 255));
    wait_drained();
    // bit 10 set is masked off for the 10-bit registers
    write_timing(11'h7ff, 11'h400, 11'h401, 11'h5aa);
    send_pixel(pack_pixel(255, 128, 3, 255));
    wait_drained();
    write_timing(0, 0, 0, 0);
    send_pixel(pack_pixel(200, 100, 50, 255));
    wait_drained();
    write_reg(REG_SPARE_LO, 11'h7ff);
    write_reg(REG_SPARE_HI, 0);
    write_timing(76, 43, 43, 96);
    send_pixel(pack_pixel(19, 240, 77, 255));
    wait_drained();
  endtask

  // Line split and frame wrap corner cases
  task automatic test_framing();
    write_reg(REG_FRAME, 1024);
    write_reg(REG_SPLIT, 512);
    repeat (8) send_pixel(rand_pixel());
    wait_drained();
    // index already past the new, shorter frame end
    write_reg(REG_FRAME, 3);
    repeat (4) send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPLIT, 0);
    repeat (4) send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPLIT, 3);
    repeat (4) send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPLIT, 2047);
    write_reg(REG_FRAME, 0);
    repeat (3) send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPLIT, 0);
    write_reg(REG_FRAME, 1);
    repeat (3) send_pixel(rand_pixel());
    wait_drained();
    write_reg(REG_SPLIT, 2);
    write_reg(REG_FRAME, 5);
    repeat (12) send_pixel(rand_pixel());
    wait_drained();
  endtask

  // Frame length written above the limit, pixels sent with no idling
  task automatic test_long_frame();
    write_reg(REG_FRAME, 2047);
    write_reg(REG_SPLIT, 1000);
    calm = 1'b1;
    repeat (40) send_pixel(rand_pixel());
    wait_drained();
    calm = 1'b0;
  endtask

  // Random pixels across several random register settings
  task automatic test_random();
    int unsigned fl;
    for (int ph = 0; ph < 4; ph++) begin
      write_timing(rand_time(), rand_time(), rand_time(), rand_time());
      fl = $urandom_range(40, 1);
      write_reg(REG_FRAME, fl);
      write_reg(REG_SPLIT, $urandom_range(fl + 2, 0));
      calm = (ph == 2);
      for (int i = 0; i < 60; i++) begin
        send_pixel(rand_pixel());
        // sender holds off until the output side is empty
        if ((ph == 0 && i == 40) || $urandom_range(49) == 0) wait_drained();
      end
      wait_drained();
    end
    calm = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("tb_rgb_led_pulse_encoder failed");
    $finish;
  end

  initial begin
    exp_one_high  = ONE_HIGH_RST;
    exp_one_low   = ONE_LOW_RST;
    exp_zero_high = ZERO_HIGH_RST;
    exp_zero_low  = ZERO_LOW_RST;
    exp_split     = SPLIT_RST;
    exp_frame     = FRAME_RST;
    pix_index     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_scaling();
    test_timing();
    test_framing();
    test_long_frame();
    test_random();
    wait_drained();

    $display("Sent %0d pixels and checked %0d pulse words after %0d register writes,",
             n_pixels, n_pulses, n_writes);
    $display("covering scaling, timing, line split and frame wrap cases; %0d errors.",
             n_errors);
    if (n_errors == 0) begin
      $display("tb_rgb_led_pulse_encoder passed");
    end else begin
      $display("tb_rgb_led_pulse_encoder failed");
    end
    $finish;
  end

endmodule
